>>> sv/bped_pkg.sv
// ----------------------------------------------------------------------------
// bped_pkg
// Shared types and constants of the biosignal peak event detector.
// ----------------------------------------------------------------------------
package bped_pkg;

    // sample and index sizing
    localparam int SAMPLE_BITS = 24;
    localparam int INDEX_BITS  = 31;

    // filter coefficient 0.95 in Q15
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 15;
    localparam int COEF_Q15    = 31130;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;

    // filtered value, derivative and detection value widths
    localparam int Y_BITS      = SAMPLE_BITS + 1;
    localparam int DIFF_BITS   = SAMPLE_BITS + 2;
    localparam int D_BITS      = SAMPLE_BITS + 3;

    // register field widths
    localparam int THR_BITS    = 26;
    localparam int GAP_BITS    = 24;
    localparam int OFS_BITS    = 31;
    localparam int CODE_BITS   = 16;
    localparam int CFG_DATA_BITS = 31;
    localparam int CFG_IDX_BITS  = 3;

    // result widths
    localparam int EVT_BITS    = 32;

    // compare widths
    localparam int THR_CMP_BITS = ((D_BITS > THR_BITS) ? D_BITS : THR_BITS) + 1;
    localparam int GAP_CMP_BITS = (INDEX_BITS > GAP_BITS) ? INDEX_BITS : GAP_BITS;

    localparam logic [CODE_BITS-1:0] EVENT_CODE_RST = CODE_BITS'(1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE       = 3'd0,
        CFG_THRESHOLD  = 3'd1,
        CFG_MIN_GAP    = 3'd2,
        CFG_START_OFS  = 3'd3,
        CFG_EVENT_CODE = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        MODE_ECG = 1'b0,
        MODE_EOG = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                 mode;
        logic [THR_BITS-1:0]   threshold;
        logic [GAP_BITS-1:0]   min_gap;
        logic [OFS_BITS-1:0]   start_offset;
        logic [CODE_BITS-1:0]  event_code;
    } t_cfg;

endpackage

>>> sv/bped_if.sv
// ----------------------------------------------------------------------------
// bped_if
// Valid/ready channels for raw samples and peak events.
// ----------------------------------------------------------------------------
interface bped_smp_if
    import bped_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;

    modport source (output valid, output sample, output first, input ready);
    modport sink   (input valid, input sample, input first, output ready);
endinterface

interface bped_evt_if
    import bped_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [EVT_BITS-1:0]   event_sample;
    logic [CODE_BITS-1:0]  ev_code;

    modport source (output valid, output event_sample, output ev_code, input ready);
    modport sink   (input valid, input event_sample, input ev_code, output ready);
endinterface

>>> sv/bped_cfg.sv
// ----------------------------------------------------------------------------
// bped_cfg
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module bped_cfg
    import bped_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_ECG;
            r_cfg.threshold    <= '0;
            r_cfg.min_gap      <= '0;
            r_cfg.start_offset <= '0;
            r_cfg.event_code   <= EVENT_CODE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_MODE:       r_cfg.mode         <= t_mode'(i_cfg_data[0]);
                CFG_THRESHOLD:  r_cfg.threshold    <= i_cfg_data[THR_BITS-1:0];
                CFG_MIN_GAP:    r_cfg.min_gap      <= i_cfg_data[GAP_BITS-1:0];
                CFG_START_OFS:  r_cfg.start_offset <= i_cfg_data[OFS_BITS-1:0];
                CFG_EVENT_CODE: r_cfg.event_code   <= i_cfg_data[CODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/bped_in_reg.sv
// ----------------------------------------------------------------------------
// bped_in_reg
// Input register: holds one accepted sample until the core takes it.
// ----------------------------------------------------------------------------
module bped_in_reg
    import bped_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bped_smp_if.sink                      i_smp,
    input  logic                          i_take,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_first
);

    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_first;
    logic                          w_load;

    // free slot, or the held sample leaves this cycle
    assign i_smp.ready = !r_valid || i_take;
    assign w_load      = i_smp.valid && i_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sample <= i_smp.sample;
            r_first  <= i_smp.first;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_first  = r_first;

endmodule

>>> sv/bped_core.sv
// ----------------------------------------------------------------------------
// bped_core
// High-pass filter, detection value, local maximum test with minimum
// distance, record state and the event result register.
// ----------------------------------------------------------------------------
module bped_core
    import bped_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_first,
    output logic                          o_take,
    bped_evt_if.source                    o_evt
);

    localparam logic signed [COEF_BITS-1:0] COEF = COEF_BITS'(COEF_Q15);
    localparam logic signed [PROD_BITS-1:0] RND  = PROD_BITS'(1) <<< (FRAC_BITS - 1);
    localparam logic [INDEX_BITS-1:0]       IDX_MAX = '1;

    // record state
    logic signed [SAMPLE_BITS-1:0] r_prev_scaled;
    logic signed [Y_BITS-1:0]      r_prev_filt;
    logic signed [D_BITS-1:0]      r_det_older;
    logic signed [D_BITS-1:0]      r_det_newer;
    logic [INDEX_BITS-1:0]         r_idx;
    logic [INDEX_BITS-1:0]         r_last_peak;
    logic                          r_peak_seen;

    // result register
    logic                          r_out_valid;
    logic [EVT_BITS-1:0]           r_out_sample;
    logic [CODE_BITS-1:0]          r_out_id;

    logic                          w_go;
    logic signed [PROD_BITS-1:0]   w_prod;
    logic signed [PROD_BITS-1:0]   w_prod_rnd;
    logic signed [SAMPLE_BITS-1:0] n_prev_scaled;
    logic signed [Y_BITS-1:0]      w_y;
    logic signed [DIFF_BITS-1:0]   w_diff;
    logic signed [D_BITS-1:0]      w_abs;
    logic signed [D_BITS-1:0]      w_d;
    logic signed [D_BITS-1:0]      w_older;
    logic signed [D_BITS-1:0]      w_newer;
    logic [INDEX_BITS-1:0]         w_n;
    logic [INDEX_BITS-1:0]         w_j;
    logic [INDEX_BITS-1:0]         w_i;
    logic [INDEX_BITS-1:0]         w_last;
    logic [INDEX_BITS-1:0]         w_dist;
    logic                          w_seen;
    logic                          w_have_det;
    logic                          w_peak;
    logic                          w_accept;
    logic signed [THR_CMP_BITS-1:0] w_newer_x;
    logic signed [THR_CMP_BITS-1:0] w_thr_x;

    assign w_go   = i_valid && (!r_out_valid || o_evt.ready);
    assign o_take = w_go;

    // scaled copy of this sample, used by the next one
    assign w_prod        = PROD_BITS'(i_sample) * PROD_BITS'(COEF);
    assign w_prod_rnd    = w_prod + RND;
    assign n_prev_scaled = SAMPLE_BITS'(w_prod_rnd >>> FRAC_BITS);

    always_comb begin
        // a first sample clears history and counters before use
        w_y     = i_first ? '0 : (Y_BITS'(i_sample) - Y_BITS'(r_prev_scaled));
        w_older = i_first ? '0 : r_det_older;
        w_newer = i_first ? '0 : r_det_newer;
        w_n     = i_first ? '0 : r_idx;
        w_seen  = i_first ? 1'b0 : r_peak_seen;
        w_last  = i_first ? '0 : r_last_peak;

        w_diff  = DIFF_BITS'(w_y) - DIFF_BITS'(r_prev_filt);
        w_abs   = w_diff[DIFF_BITS-1] ? D_BITS'(-w_diff) : D_BITS'(w_diff);

        if (i_cfg.mode == MODE_EOG) begin
            w_d        = w_abs;
            w_have_det = (w_n != '0);
            w_j        = w_n - INDEX_BITS'(1);
        end else begin
            w_d        = D_BITS'(w_y);
            w_have_det = 1'b1;
            w_j        = w_n;
        end

        w_i       = w_j - INDEX_BITS'(1);
        w_newer_x = THR_CMP_BITS'(w_newer);
        w_thr_x   = $signed({{(THR_CMP_BITS-THR_BITS){1'b0}}, i_cfg.threshold});

        w_peak = w_have_det && (w_j > INDEX_BITS'(1)) && (w_newer_x > w_thr_x)
                 && (w_newer > w_older) && (w_newer > w_d);

        // distance to the last peak, absolute once the index has saturated
        w_dist = (w_i >= w_last) ? (w_i - w_last) : (w_last - w_i);

        w_accept = w_peak && (!w_seen ||
                   (GAP_CMP_BITS'(w_dist) >= GAP_CMP_BITS'(i_cfg.min_gap)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_scaled <= '0;
            r_prev_filt   <= '0;
            r_det_older   <= '0;
            r_det_newer   <= '0;
            r_idx         <= '0;
            r_last_peak   <= '0;
            r_peak_seen   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_go) begin
                r_prev_scaled <= n_prev_scaled;
                r_prev_filt   <= w_y;
                r_idx         <= (w_n == IDX_MAX) ? IDX_MAX : (w_n + INDEX_BITS'(1));
                if (w_have_det) begin
                    r_det_older <= w_newer;
                    r_det_newer <= w_d;
                end else begin
                    r_det_older <= w_older;
                    r_det_newer <= w_newer;
                end
                if (w_accept) begin
                    r_peak_seen <= 1'b1;
                    r_last_peak <= w_i;
                end else begin
                    r_peak_seen <= w_seen;
                    r_last_peak <= w_last;
                end
            end
            if (w_go && w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_accept) begin
            r_out_sample <= EVT_BITS'(i_cfg.start_offset) + EVT_BITS'(w_i);
            r_out_id     <= i_cfg.event_code;
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_sample = r_out_sample;
    assign o_evt.ev_code      = r_out_id;

    // a new event is only loaded from an item taken in the cycle before
    a_evt_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_go))
        else $error("event appeared without a processed sample");

    // record start clears the accepted-peak flag and the last peak index
    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && i_first) |=> (!r_peak_seen && r_last_peak == '0))
        else $error("record start did not clear peak history");

    // index never moves back inside a record
    a_idx_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && !i_first) |=> (r_idx >= $past(r_idx) && r_idx != '0))
        else $error("sample index went backward");

endmodule

>>> sv/biosignal_peak_event_detector_unit.sv
// ----------------------------------------------------------------------------
// biosignal_peak_event_detector_unit
// Streaming ECG/EOG peak detector producing one event per accepted peak.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle unless the input side stalls. A sample
// lands in an input register, passes the filter, detection and peak test
// when the core takes it; an event it confirms is held in a result register.
// The result register and the input register let a new sample transfer while
// an event waits; the input side stalls only when both are full. Samples are
// reported against the detection value that follows them, so a peak is seen
// one sample (ECG) or two samples (EOG) after its own index.
module biosignal_peak_event_detector_unit
    import bped_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    bped_smp_if.sink                 i_smp,
    bped_evt_if.source               o_evt
);

    t_cfg                          w_cfg;
    logic                          w_valid;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic                          w_first;
    logic                          w_take;

    bped_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bped_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (i_smp),
        .i_take   (w_take),
        .o_valid  (w_valid),
        .o_sample (w_sample),
        .o_first  (w_first)
    );

    bped_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_valid),
        .i_sample (w_sample),
        .i_first  (w_first),
        .o_take   (w_take),
        .o_evt    (o_evt)
    );

endmodule
